### hw/rtl/tscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_pkg
// Widths, table entry layout and write-port bundle shared by the
// continuity loss counter.
// ----------------------------------------------------------------------------
package tscc_pkg;

  localparam int PID_BITS   = 13;
  localparam int CC_BITS    = 4;
  localparam int COUNT_BITS = 32;

  localparam int TBL_DEPTH  = 2 ** PID_BITS;

  // One table entry per PID: seen flag, last counter, lost total
  typedef struct packed {
    logic                  seen;
    logic [CC_BITS-1:0]    last_cc;
    logic [COUNT_BITS-1:0] lost_count;
  } entry_t;

  // Table write port
  typedef struct packed {
    logic                en;
    logic [PID_BITS-1:0] addr;
    entry_t              data;
  } tbl_wr_t;

endpackage

### hw/rtl/tscc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_hdr_if / tscc_res_if
// Valid/ready channels for packet header words and check result words.
// ----------------------------------------------------------------------------
interface tscc_hdr_if import tscc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PID_BITS-1:0] pid;
  logic [CC_BITS-1:0]  cont_count;
  logic                last_in_buffer;

  modport source (output valid, output pid, output cont_count, output last_in_buffer,
                  input ready);
  modport sink   (input valid, input pid, input cont_count, input last_in_buffer,
                  output ready);
endinterface

interface tscc_res_if import tscc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PID_BITS-1:0]   pid_echo;
  logic                  first_seen;
  logic [CC_BITS-1:0]    skipped_now;
  logic [COUNT_BITS-1:0] lost_total;
  logic                  end_of_batch;

  modport source (output valid, output pid_echo, output first_seen, output skipped_now,
                  output lost_total, output end_of_batch, input ready);
  modport sink   (input valid, input pid_echo, input first_seen, input skipped_now,
                  input lost_total, input end_of_batch, output ready);
endinterface

### hw/rtl/tscc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_update
// Entry update: continuity skip, saturating total and the new entry value.
// ----------------------------------------------------------------------------
module tscc_update import tscc_pkg::*; (
  input  entry_t                cur,
  input  logic [CC_BITS-1:0]    cc,
  output entry_t                upd,
  output logic                  first,
  output logic [CC_BITS-1:0]    skip,
  output logic [COUNT_BITS-1:0] total
);

  logic [COUNT_BITS:0] sum;

  // skip = (cc - last - 1) mod 2^CC_BITS, and -last-1 is ~last
  always_comb begin
    first = ~cur.seen;
    skip  = first ? '0 : CC_BITS'(cc + ~cur.last_cc);
    sum   = {1'b0, cur.lost_count} + {{(COUNT_BITS + 1 - CC_BITS){1'b0}}, skip};
    if (first) begin
      total = '0;
    end else if (sum[COUNT_BITS]) begin
      total = '1;
    end else begin
      total = sum[COUNT_BITS-1:0];
    end
    upd.seen       = 1'b1;
    upd.last_cc    = cc;
    upd.lost_count = total;
  end

endmodule

### hw/rtl/ts_continuity_loss_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_continuity_loss_counter_core
// Per-PID continuity counter check with saturating lost-packet totals kept
// in a single read-modify-write table.
//
//   channel | dir | word
//   hdr     | in  | pid, cont_count, last_in_buffer
//   res     | out | pid_echo, first_seen, skipped_now, lost_total, end_of_batch
//
// One header per cycle sustained while results are taken; headers pass the check
// stage, then the result register. Table read is registered; a same-PID header
// right behind another takes the written entry from a forwarding register instead
// of the stale read. After reset a clearing pass writes all 8192 entries with
// hdr.ready low. A stalled result holds the pipeline; hdr.ready then drops.
// ----------------------------------------------------------------------------
module ts_continuity_loss_counter_core import tscc_pkg::*; (
  input logic      clk,
  input logic      rst,
  tscc_hdr_if.sink   hdr,
  tscc_res_if.source res
);

  // Table
  entry_t mem [TBL_DEPTH];
  entry_t rd_data;
  tbl_wr_t wr;

  // Clearing pass
  logic                clearing;
  logic [PID_BITS-1:0] clr_addr;

  // Check stage
  logic                s1_valid;
  logic [PID_BITS-1:0] s1_pid;
  logic [CC_BITS-1:0]  s1_cc;
  logic                s1_eob;
  logic                fwd_hit;
  entry_t              fwd_data;
  entry_t              cur;
  entry_t              upd;
  logic                first;
  logic [CC_BITS-1:0]  skip;
  logic [COUNT_BITS-1:0] total;
  logic                s1_adv;
  logic                accept;

  // Result register
  logic                  out_valid;
  logic [PID_BITS-1:0]   out_pid;
  logic                  out_first;
  logic [CC_BITS-1:0]    out_skip;
  logic [COUNT_BITS-1:0] out_total;
  logic                  out_eob;

  // Handshake
  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign hdr.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = hdr.valid && hdr.ready;

  // Table ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[hdr.pid];
    end
  end

  always_comb begin
    if (clearing) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else begin
      wr.en   = s1_adv;
      wr.addr = s1_pid;
      wr.data = upd;
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Check stage: capture header and forwarding state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pid   <= hdr.pid;
      s1_cc    <= hdr.cont_count;
      s1_eob   <= hdr.last_in_buffer;
      fwd_hit  <= s1_adv && (s1_pid == hdr.pid);
      fwd_data <= upd;
    end
  end

  assign cur = fwd_hit ? fwd_data : rd_data;

  tscc_update u_update (
    .cur   (cur),
    .cc    (s1_cc),
    .upd   (upd),
    .first (first),
    .skip  (skip),
    .total (total)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pid   <= s1_pid;
      out_first <= first;
      out_skip  <= skip;
      out_total <= total;
      out_eob   <= s1_eob;
    end
  end

  assign res.valid        = out_valid;
  assign res.pid_echo     = out_pid;
  assign res.first_seen   = out_first;
  assign res.skipped_now  = out_skip;
  assign res.lost_total   = out_total;
  assign res.end_of_batch = out_eob;

  // Checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !hdr.ready)
    else $error("header accepted during clearing pass");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == '1)
    else $error("clearing pass ended early");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_first |-> out_skip == '0 && out_total == '0)
    else $error("first packet reported nonzero loss");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_pid) && $stable(s1_cc))
    else $error("check stage lost its word while stalled");

endmodule

### bench/ts_continuity_loss_counter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_continuity_loss_counter_checker
// Watches the header and result channels of the continuity loss counter,
// tracks per-PID continuity state on its own and compares every result
// word, field by field, against the oldest predicted word.
// ----------------------------------------------------------------------------
module ts_continuity_loss_counter_checker import tscc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tscc_hdr_if        hdr,
  tscc_res_if        res,
  output int         mismatch_count,
  output int         words_pending
);

  localparam logic [COUNT_BITS-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [PID_BITS-1:0]   pid_echo;
    logic                  first_seen;
    logic [CC_BITS-1:0]    skipped_now;
    logic [COUNT_BITS-1:0] lost_total;
    logic                  end_of_batch;
  } loss_word_t;

  // Shadow of the per-PID table
  logic                  pid_seen   [TBL_DEPTH];
  logic [CC_BITS-1:0]    pid_last   [TBL_DEPTH];
  logic [COUNT_BITS-1:0] pid_losses [TBL_DEPTH];

  loss_word_t loss_words_due [$];
  int         fail_tally;
  int         due_count;

  assign mismatch_count = fail_tally;
  assign words_pending  = due_count;

  initial begin
    fail_tally = 0;
    due_count  = 0;
    foreach (pid_seen[i]) pid_seen[i] = 1'b0;
  end

  // Continuity check of one header; updates the shadow table
  function automatic loss_word_t track_continuity(input logic [PID_BITS-1:0] pid,
                                                  input logic [CC_BITS-1:0] cc,
                                                  input logic last);
    loss_word_t          w;
    logic [CC_BITS-1:0]  skip;
    logic [COUNT_BITS:0] sum;
    w.pid_echo     = pid;
    w.end_of_batch = last;
    if (!pid_seen[pid]) begin
      w.first_seen    = 1'b1;
      w.skipped_now   = '0;
      w.lost_total    = '0;
      pid_seen[pid]   = 1'b1;
      pid_losses[pid] = '0;
    end else begin
      // mod-16 wrap comes from the width; a repeat gives 15
      skip = cc - pid_last[pid] - 1'b1;
      sum  = {1'b0, pid_losses[pid]} + {{(COUNT_BITS + 1 - CC_BITS){1'b0}}, skip};
      w.first_seen    = 1'b0;
      w.skipped_now   = skip;
      w.lost_total    = sum[COUNT_BITS] ? TOTAL_MAX : sum[COUNT_BITS-1:0];
      pid_losses[pid] = w.lost_total;
    end
    pid_last[pid] = cc;
    return w;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endfunction

  // Result words first, then new headers; latency keeps them apart
  always @(posedge clk) begin
    loss_word_t w;
    if (rst) begin
      foreach (pid_seen[i]) pid_seen[i] = 1'b0;
      loss_words_due.delete();
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (loss_words_due.size() == 0) begin
          $error("result word with nothing due: pid_echo=%0d", res.pid_echo);
          fail_tally++;
        end else begin
          w = loss_words_due.pop_front();
          check_field("pid_echo",     w.pid_echo,     res.pid_echo);
          check_field("first_seen",   w.first_seen,   res.first_seen);
          check_field("skipped_now",  w.skipped_now,  res.skipped_now);
          check_field("lost_total",   w.lost_total,   res.lost_total);
          check_field("end_of_batch", w.end_of_batch, res.end_of_batch);
        end
      end
      if (hdr.valid === 1'b1 && hdr.ready === 1'b1)
        loss_words_due.push_back(track_continuity(hdr.pid, hdr.cont_count,
                                                  hdr.last_in_buffer));
    end
    due_count = loss_words_due.size();
  end

endmodule

### bench/ts_continuity_loss_counter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_continuity_loss_counter_core_tb
// Drives packet header words into the continuity loss counter with random
// gaps on both channels, a long result stall and a full drain pause; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module ts_continuity_loss_counter_core_tb;
  import tscc_pkg::*;

  localparam int LONG_STALL = 400;
  localparam int TAIL_WAIT  = 10;

  logic clk = 1'b0;
  logic rst;
  int   mismatch_count;
  int   words_pending;
  bit   stall_req = 1'b0;
  bit   quiet     = 1'b0;

  // Next in-order counter per PID in the current pool
  logic [CC_BITS-1:0]  cc_track [int];
  logic [PID_BITS-1:0] pid_pool [6];

  tscc_hdr_if hdr_ch ();
  tscc_res_if res_ch ();

  ts_continuity_loss_counter_core dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr_ch),
    .res (res_ch)
  );

  ts_continuity_loss_counter_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .hdr            (hdr_ch),
    .res            (res_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones, none at all while quiet
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_header(input logic [PID_BITS-1:0] pid, input logic [CC_BITS-1:0] cc,
                             input logic last, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      hdr_ch.valid          <= 1'b0;
      hdr_ch.pid            <= PID_BITS'($urandom);
      hdr_ch.cont_count     <= CC_BITS'($urandom);
      hdr_ch.last_in_buffer <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    hdr_ch.valid          <= 1'b1;
    hdr_ch.pid            <= pid;
    hdr_ch.cont_count     <= cc;
    hdr_ch.last_in_buffer <= last;
    do @(posedge clk); while (hdr_ch.ready !== 1'b1);
  endtask

  // Pool header: mostly in order, some repeats and jumps
  task automatic send_pool_header(input int gap);
    logic [PID_BITS-1:0] pid;
    logic [CC_BITS-1:0]  cc;
    int                  r;
    pid = pid_pool[3'($urandom_range(0, 5))];
    r   = $urandom_range(0, 99);
    if (!cc_track.exists(pid) || r >= 90) cc = CC_BITS'($urandom);
    else if (r < 80) cc = cc_track[pid];
    else cc = cc_track[pid] - 1'b1;
    cc_track[pid] = cc + 1'b1;
    send_header(pid, cc, ($urandom_range(0, 7) == 0), gap);
  endtask

  task automatic new_pool();
    foreach (pid_pool[i]) pid_pool[i] = PID_BITS'($urandom);
    if ($urandom_range(0, 1)) pid_pool[0] = '0;
    if ($urandom_range(0, 1)) pid_pool[1] = '1;
  endtask

  task automatic drain();
    @(negedge clk);
    hdr_ch.valid <= 1'b0;
    @(negedge clk);
    wait (words_pending == 0);
  endtask

  // Result side: random ready bursts, or one long hold-off on request
  initial begin
    int  lvl_left;
    bit  lvl;
    int  idle;
    res_ch.ready = 1'b0;
    lvl          = 1'b1;
    lvl_left     = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        stall_req = 1'b0;
        lvl       = 1'b1;
        lvl_left  = 0;
      end else begin
        if (lvl_left == 0) begin
          if (lvl) begin
            idle = idle_span();
            if (idle > 0) begin
              lvl      = 1'b0;
              lvl_left = idle;
            end else begin
              lvl_left = $urandom_range(1, 24);
            end
          end else begin
            lvl      = 1'b1;
            lvl_left = $urandom_range(1, 24);
          end
        end
        res_ch.ready <= lvl;
        lvl_left--;
      end
    end
  end

  // Stimulus
  initial begin
    hdr_ch.valid          = 1'b0;
    hdr_ch.pid            = '0;
    hdr_ch.cont_count     = '0;
    hdr_ch.last_in_buffer = 1'b0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: first packets, in-order, repeats, wrap, back-to-back forwarding
    send_header(13'd0,      4'd0,  1'b0, 0);
    send_header(13'd0,      4'd1,  1'b0, 0);
    send_header(13'd0,      4'd1,  1'b0, 0);
    send_header(13'd8191,   4'd15, 1'b1, 0);
    send_header(13'd8191,   4'd0,  1'b0, 0);
    send_header(13'd8191,   4'd15, 1'b0, 0);
    send_header(13'd0,      4'd5,  1'b1, 1);
    send_header(13'h1555,   4'd10, 1'b0, 0);
    send_header(13'h0aaa,   4'd5,  1'b0, 0);
    send_header(13'h1555,   4'd10, 1'b0, 0);
    send_header(13'h0aaa,   4'd6,  1'b0, 0);
    send_header(13'd0,      4'd4,  1'b0, 0);
    send_header(13'd0,      4'd4,  1'b0, 0);
    send_header(13'd0,      4'd4,  1'b0, 0);
    send_header(13'd8191,   4'd15, 1'b1, 2);
    send_header(13'd8191,   4'd14, 1'b0, 0);
    send_header(13'h1555,   4'd9,  1'b0, 1);
    send_header(13'h1555,   4'd8,  1'b0, 1);
    send_header(13'd1,      4'd0,  1'b0, 0);
    send_header(13'd1,      4'd15, 1'b1, 0);

    // Pooled PIDs with random gaps
    new_pool();
    repeat (240) send_pool_header(idle_span());

    // Long result hold-off while headers keep coming
    @(negedge clk);
    stall_req = 1'b1;
    repeat (60) send_pool_header(0);
    drain();

    // No idling on either side, fresh pool
    quiet = 1'b1;
    new_pool();
    repeat (150) send_pool_header(0);
    quiet = 1'b0;

    // Whole PID range, random counters
    repeat (150) send_header(PID_BITS'($urandom), CC_BITS'($urandom), 1'($urandom),
                             idle_span());

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("ts_continuity_loss_counter_core_tb: done, clean");
    end else begin
      $display("ts_continuity_loss_counter_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("ts_continuity_loss_counter_core_tb: done, errors");
    $finish;
  end

endmodule
